// ----- rtl/crgd_pkg.sv -----
// Package for the column run-length glyph decoder.
// Holds frame constants, register indexes, configuration and command types.
// No dependencies.
`default_nettype none
package crgd_pkg;

	localparam int FRAME_WIDTH  = 320;
	localparam int FRAME_HEIGHT = 200;
	localparam int FRAME_SIZE   = FRAME_WIDTH * FRAME_HEIGHT;

	localparam int POS_W   = 17;
	localparam int ADDR_W  = 20;
	localparam int COLS_W  = 9;
	localparam int IDATA_W = 40;
	localparam int ODATA_W = 32;
	localparam int CFG_W   = 64;
	localparam int CIDX_W  = 2;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);

	localparam logic [POS_W-1:0] ROW_STEP = POS_W'(FRAME_WIDTH);

	localparam logic       MODE_START   = 1'b0;
	localparam logic       MODE_DATA    = 1'b1;
	localparam logic [7:0] COL_END_BYTE = 8'h80;
	localparam logic [7:0] ZERO_BYTE    = 8'h00;

	typedef enum logic [CIDX_W-1:0] {
		CFG_PALETTE_LOW  = 2'd0,
		CFG_PALETTE_HIGH = 2'd1,
		CFG_ZERO_ADV     = 2'd2,
		CFG_FRAME_BASE   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [63:0]       palette_low;
		logic [63:0]       palette_high;
		logic              zero_adv;
		logic [ADDR_W-1:0] frame_base;
	} cfg_t;

	typedef enum logic [2:0] {
		CMD_START,
		CMD_COL_END,
		CMD_MOVE,
		CMD_NOP,
		CMD_PAINT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [POS_W-1:0] value;
		logic [3:0]       count;
		logic [3:0]       colour_idx;
		logic             done;
	} cmd_t;

endpackage
`default_nettype wire

// ----- rtl/crgd_front.sv -----
// Front end: accepts input beats, tracks columns left, classifies bytes into commands.
// Depends on crgd_pkg.
`default_nettype none
module crgd_front import crgd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [IDATA_W-1:0] s_tdata,  // origin_x, origin_y, column_count, data_byte
	input  wire logic               s_tuser,  // mode
	input  wire cfg_t               cfg,
	input  wire logic               q_full,
	output logic                    q_push,
	output cmd_t                    q_cmd
);

	logic [COLS_W-1:0] cols_q;
	logic [COLS_W-1:0] cols_next;
	logic [8:0]        org_x;
	logic [7:0]        org_y;
	logic [8:0]        col_cnt;
	logic [7:0]        b;
	logic              accept;

	assign org_x   = s_tdata[8:0];
	assign org_y   = s_tdata[16:9];
	assign col_cnt = s_tdata[25:17];
	assign b       = s_tdata[33:26];

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		q_cmd      = '0;
		q_cmd.kind = CMD_NOP;
		cols_next  = cols_q;
		q_push     = 1'b0;
		if (s_tuser == MODE_START) begin
			cols_next   = col_cnt;
			q_cmd.kind  = CMD_START;
			q_cmd.value = POS_W'(POS_W'(org_y) * ROW_STEP + POS_W'(org_x));
			q_push      = accept;
		end else if (cols_q != '0) begin
			q_push = accept;
			if (b == COL_END_BYTE) begin
				q_cmd.kind = CMD_COL_END;
				cols_next  = cols_q - COLS_W'(1);
			end else if (b[7]) begin
				q_cmd.kind  = CMD_MOVE;
				q_cmd.value = POS_W'({10'b0, b[6:0]} * ROW_STEP);
			end else if (b == ZERO_BYTE && cfg.zero_adv) begin
				q_cmd.kind  = CMD_MOVE;
				q_cmd.value = ROW_STEP;
			end else if (b[7:4] == 4'd0) begin
				q_cmd.kind = CMD_NOP;
			end else begin
				q_cmd.kind       = CMD_PAINT;
				q_cmd.count      = b[7:4];
				q_cmd.colour_idx = b[3:0];
			end
		end
		q_cmd.done = (cols_next == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= '0;
		end else if (accept) begin
			cols_q <= cols_next;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/crgd_fifo.sv -----
// Short command queue between front and back ends.
// Depends on crgd_pkg.
`default_nettype none
module crgd_fifo import crgd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	input  wire logic pop,
	output cmd_t      rdata,
	output logic      full,
	output logic      empty
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_W+1)'(QDEPTH)) else $error("queue count out of range");

endmodule
`default_nettype wire

// ----- rtl/crgd_back.sv -----
// Back end: executes queued commands, walks rows and emits output beats.
// Depends on crgd_pkg.
`default_nettype none
module crgd_back import crgd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire cmd_t               q_cmd,
	input  wire logic               q_empty,
	output logic                    q_pop,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [ODATA_W-1:0]      m_tdata,  // write_address, pixel_colour, out_of_frame, glyph_done
	output logic                    m_tuser,  // write_valid
	output logic                    m_tlast   // last_of_run
);

	cmd_t              cur_q;
	logic              cur_valid_q;
	logic [POS_W-1:0]  col_org_q;
	logic [POS_W-1:0]  row_q;

	logic              out_valid_q;
	logic              out_wv_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [7:0]        out_colour_q;
	logic              out_oof_q;
	logic              out_last_q;
	logic              out_done_q;

	logic              can_load;
	logic              emit;
	logic              e_wv;
	logic              e_last;
	logic              finish;
	logic [POS_W-1:0]  row_next;
	logic [POS_W-1:0]  org_next;
	logic [127:0]      palette;
	logic [7:0]        colour;

	assign can_load = !out_valid_q || m_tready;
	assign q_pop    = !cur_valid_q && !q_empty;
	assign palette  = {cfg.palette_high, cfg.palette_low};
	assign colour   = palette[{cur_q.colour_idx, 3'b000} +: 8];

	always_comb begin
		emit     = 1'b0;
		e_wv     = 1'b0;
		e_last   = 1'b1;
		finish   = 1'b0;
		row_next = row_q;
		org_next = col_org_q;
		if (cur_valid_q) begin
			case (cur_q.kind)
				CMD_START: begin
					finish   = 1'b1;
					org_next = cur_q.value;
					row_next = cur_q.value;
				end
				CMD_COL_END: begin
					emit     = can_load;
					finish   = can_load;
					if (can_load) begin
						org_next = col_org_q + POS_W'(1);
						row_next = col_org_q + POS_W'(1);
					end
				end
				CMD_MOVE: begin
					emit   = can_load;
					finish = can_load;
					if (can_load) begin
						row_next = row_q + cur_q.value;
					end
				end
				CMD_PAINT: begin
					emit   = can_load;
					e_wv   = 1'b1;
					e_last = (cur_q.count == 4'd1);
					finish = can_load && e_last;
					if (can_load) begin
						row_next = row_q + ROW_STEP;
					end
				end
				default: begin
					emit   = can_load;
					finish = can_load;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			col_org_q   <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			col_org_q <= org_next;
			row_q     <= row_next;
			if (q_pop) begin
				cur_valid_q <= 1'b1;
			end else if (finish) begin
				cur_valid_q <= 1'b0;
			end
			if (can_load) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_cmd;
		end else if (emit && cur_q.kind == CMD_PAINT) begin
			cur_q.count <= cur_q.count - 4'd1;
		end
		if (emit) begin
			out_wv_q     <= e_wv;
			out_last_q   <= e_last;
			out_done_q   <= cur_q.done;
			out_addr_q   <= e_wv ? cfg.frame_base + ADDR_W'(row_q) : '0;
			out_colour_q <= e_wv ? colour : 8'd0;
			out_oof_q    <= e_wv && (32'(row_q) >= FRAME_SIZE);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_wv_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b00, out_done_q, out_oof_q, out_colour_q, out_addr_q};

	a_nowrite_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_wv_q |-> out_last_q) else $error("non-write beat not last");
	a_paint_count: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q && cur_q.kind == CMD_PAINT |-> cur_q.count != 4'd0)
		else $error("paint command with zero count");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> !q_pop) else $error("pop while command busy");

endmodule
`default_nettype wire

// ----- rtl/column_rle_glyph_decoder.sv -----
// Column run-length glyph decoder, top level.
// Holds configuration registers; joins crgd_front, crgd_fifo and crgd_back.
// Depends on crgd_pkg.
//
// Input beats (s_tvalid/s_tready/s_tdata/s_tuser): s_tuser 0 starts a glyph with
// origin and column count, s_tuser 1 carries one encoded byte. Output beats
// (m_tvalid/m_tready/m_tdata/m_tuser/m_tlast): m_tuser marks a pixel write,
// m_tlast marks the last beat caused by one input beat.
// A start beat and a data beat with no columns left give no output beat. A colour
// byte gives one beat per written row; every other data byte gives one beat.
// The front end accepts a beat per cycle while the queue is not full, into a
// four-entry command queue. The back end takes one command at a time and pops the
// next only when the current one is done, then emits one beat per cycle while the
// receiver is ready. Output passes the queue, command register and output register.
// A stalled receiver holds the output register; the back end then stops, the
// queue fills and s_tready drops when it is full.
// Reset clears configuration, glyph state, queue and output valid; the block is
// ready when reset is released. Write configuration only while idle.
`default_nettype none
module column_rle_glyph_decoder import crgd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [IDATA_W-1:0] s_tdata,  // origin_x, origin_y, column_count, data_byte
	input  wire logic               s_tuser,  // mode
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [ODATA_W-1:0]      m_tdata,  // write_address, pixel_colour, out_of_frame, glyph_done
	output logic                    m_tuser,  // write_valid
	output logic                    m_tlast,  // last_of_run
	input  wire logic               cfg_wen,
	input  wire logic [CIDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_wdata
);

	cfg_t cfg_q;
	cmd_t push_cmd;
	cmd_t pop_cmd;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PALETTE_LOW:  cfg_q.palette_low  <= cfg_wdata;
				CFG_PALETTE_HIGH: cfg_q.palette_high <= cfg_wdata;
				CFG_ZERO_ADV:     cfg_q.zero_adv     <= cfg_wdata[0];
				CFG_FRAME_BASE:   cfg_q.frame_base   <= cfg_wdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	crgd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	crgd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_cmd),
		.pop    (q_pop),
		.rdata  (pop_cmd),
		.full   (q_full),
		.empty  (q_empty)
	);

	crgd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_cmd    (pop_cmd),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire
